@@ sv/mkd_pkg.sv @@
// ---------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, register codes, reset values and the Morse tree lookup.
// ---------------------------------------------------------------------------
package mkd_pkg;

   localparam int COUNT_WIDTH    = 10;
   localparam int CFG_WIDTH      = 10;
   localparam int CMP_WIDTH      = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int TREE_WIDTH     = 5;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [CFG_WIDTH-1:0] DASH_RESET       = CFG_WIDTH'(50);
   localparam logic [CFG_WIDTH-1:0] LETTER_GAP_RESET = CFG_WIDTH'(100);
   localparam logic [CFG_WIDTH-1:0] WORD_GAP_RESET   = CFG_WIDTH'(500);

   localparam logic [TREE_WIDTH-1:0] TREE_ROOT = TREE_WIDTH'(1);

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      REG_DASH       = 2'd0,
      REG_LETTER_GAP = 2'd1,
      REG_WORD_GAP   = 2'd2
   } csr_reg_type;

   function automatic logic [7:0] tree_char(input logic [TREE_WIDTH-1:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd2:    ch = "e";
         5'd3:    ch = "t";
         5'd4:    ch = "i";
         5'd5:    ch = "a";
         5'd6:    ch = "n";
         5'd7:    ch = "m";
         5'd8:    ch = "s";
         5'd9:    ch = "u";
         5'd10:   ch = "r";
         5'd11:   ch = "w";
         5'd12:   ch = "d";
         5'd13:   ch = "k";
         5'd14:   ch = "g";
         5'd15:   ch = "o";
         5'd16:   ch = "h";
         5'd17:   ch = "v";
         5'd18:   ch = "f";
         5'd20:   ch = "l";
         5'd22:   ch = "p";
         5'd23:   ch = "j";
         5'd24:   ch = "b";
         5'd25:   ch = "x";
         5'd26:   ch = "c";
         5'd27:   ch = "y";
         5'd28:   ch = "z";
         5'd29:   ch = "q";
         default: ch = SPACE_CHAR;
      endcase
      return ch;
   endfunction

endpackage

@@ sv/morse_key_decoder.sv @@
// Results of a key sample appear in the cycle after its beat is accepted.
// Throughput: one key sample per cycle unless rsp_stall holds the output;
// a word end gives two beats (letter, then space); the input waits for both.
// Reset (synchronous, active high): thresholds return to 50/100/500 ticks,
// counters clear, the tree walk returns to its root and the output empties.
// ---------------------------------------------------------------------------
// Morse key decoder
// Classifies key presses as dots or dashes, walks the Morse tree and emits
// letters on letter gaps and a letter plus space on word gaps.
// ---------------------------------------------------------------------------
module morse_key_decoder
   import mkd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_key_down,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_char_valid,
   output logic [7:0]                rsp_character,
   output logic                      rsp_led_on,
   output logic                      rsp_last,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [CFG_WIDTH-1:0]   dash_ff, dash_in;
   logic [CFG_WIDTH-1:0]   letter_gap_ff, letter_gap_in;
   logic [CFG_WIDTH-1:0]   word_gap_ff, word_gap_in;

   logic [COUNT_WIDTH-1:0] press_ff, press_in;
   logic [COUNT_WIDTH-1:0] gap_ff, gap_in;
   logic [TREE_WIDTH-1:0]  idx_ff, idx_in;
   logic                   ovf_ff, ovf_in;
   logic                   started_ff, started_in;
   logic                   was_down_ff, was_down_in;

   logic                   res_valid_ff, res_valid_in;
   logic                   res_two_ff, res_two_in;
   logic                   res_char_valid_ff, res_char_valid_in;
   logic [7:0]             res_char_ff, res_char_in;
   logic                   res_led_ff, res_led_in;

   logic                   csr_wr;
   csr_reg_type            csr_reg;
   logic                   in_take, out_take, out_free;

   logic                   emit, word_end, led, dash_bit;
   logic [7:0]             ch;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      dash_in       = dash_ff;
      letter_gap_in = letter_gap_ff;
      word_gap_in   = word_gap_ff;
      csr_prdata    = '0;
      case (csr_reg)
         REG_DASH: begin
            csr_prdata = CSR_DATA_WIDTH'(dash_ff);
            if (csr_wr) dash_in = csr_pwdata[CFG_WIDTH-1:0];
         end
         REG_LETTER_GAP: begin
            csr_prdata = CSR_DATA_WIDTH'(letter_gap_ff);
            if (csr_wr) letter_gap_in = csr_pwdata[CFG_WIDTH-1:0];
         end
         REG_WORD_GAP: begin
            csr_prdata = CSR_DATA_WIDTH'(word_gap_ff);
            if (csr_wr) word_gap_in = csr_pwdata[CFG_WIDTH-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   // handshake
   assign out_take  = res_valid_ff && !rsp_stall;
   assign out_free  = !res_valid_ff || (out_take && !res_two_ff);
   assign req_stall = !out_free;
   assign in_take   = req_valid && out_free;

   // decode step
   always_comb begin
      press_in    = press_ff;
      gap_in      = gap_ff;
      idx_in      = idx_ff;
      ovf_in      = ovf_ff;
      started_in  = started_ff;
      was_down_in = req_key_down;
      emit        = 1'b0;
      word_end    = 1'b0;
      ch          = 8'h00;
      led         = 1'b0;
      dash_bit    = CMP_WIDTH'(press_ff) > CMP_WIDTH'(dash_ff);

      if (req_key_down) begin
         if (!was_down_ff) begin
            if (started_ff && CMP_WIDTH'(gap_ff) >= CMP_WIDTH'(letter_gap_ff)
                && CMP_WIDTH'(gap_ff) < CMP_WIDTH'(word_gap_ff)) begin
               ch     = ovf_ff ? SPACE_CHAR : tree_char(idx_ff);
               emit   = 1'b1;
               idx_in = TREE_ROOT;
               ovf_in = 1'b0;
            end
            gap_in     = '0;
            press_in   = '0;
            started_in = 1'b1;
         end
         if (press_in != COUNT_MAX) press_in = press_in + COUNT_WIDTH'(1);
         led = CMP_WIDTH'(press_in) > CMP_WIDTH'(dash_ff);
      end else begin
         if (was_down_ff) begin
            if (idx_ff[TREE_WIDTH-1]) ovf_in = 1'b1;
            idx_in   = {idx_ff[TREE_WIDTH-2:0], dash_bit};
            press_in = '0;
            gap_in   = '0;
         end
         if (started_ff) begin
            if (gap_in != COUNT_MAX) gap_in = gap_in + COUNT_WIDTH'(1);
            if (CMP_WIDTH'(gap_in) >= CMP_WIDTH'(word_gap_ff)) begin
               ch         = ovf_in ? SPACE_CHAR : tree_char(idx_in);
               emit       = 1'b1;
               word_end   = 1'b1;
               idx_in     = TREE_ROOT;
               ovf_in     = 1'b0;
               started_in = 1'b0;
               gap_in     = '0;
            end
         end
      end
   end

   // result register
   always_comb begin
      res_valid_in      = res_valid_ff;
      res_two_in        = res_two_ff;
      res_char_valid_in = res_char_valid_ff;
      res_char_in       = res_char_ff;
      res_led_in        = res_led_ff;
      if (in_take) begin
         res_valid_in      = 1'b1;
         res_two_in        = word_end;
         res_char_valid_in = emit;
         res_char_in       = ch;
         res_led_in        = led;
      end else if (out_take) begin
         if (res_two_ff) begin
            res_two_in  = 1'b0;
            res_char_in = SPACE_CHAR;
         end else begin
            res_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ff       <= DASH_RESET;
         letter_gap_ff <= LETTER_GAP_RESET;
         word_gap_ff   <= WORD_GAP_RESET;
         press_ff      <= '0;
         gap_ff        <= '0;
         idx_ff        <= TREE_ROOT;
         ovf_ff        <= 1'b0;
         started_ff    <= 1'b0;
         was_down_ff   <= 1'b0;
         res_valid_ff  <= 1'b0;
         res_two_ff    <= 1'b0;
      end else begin
         dash_ff       <= dash_in;
         letter_gap_ff <= letter_gap_in;
         word_gap_ff   <= word_gap_in;
         res_valid_ff  <= res_valid_in;
         res_two_ff    <= res_two_in;
         if (in_take) begin
            press_ff    <= press_in;
            gap_ff      <= gap_in;
            idx_ff      <= idx_in;
            ovf_ff      <= ovf_in;
            started_ff  <= started_in;
            was_down_ff <= was_down_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_char_valid_ff <= res_char_valid_in;
      res_char_ff       <= res_char_in;
      res_led_ff        <= res_led_in;
   end

   assign rsp_valid      = res_valid_ff;
   assign rsp_char_valid = res_char_valid_ff;
   assign rsp_character  = res_char_ff;
   assign rsp_led_on     = res_led_ff;
   assign rsp_last       = !res_two_ff;

`ifndef SYNTHESIS
   a_space_follows: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_two_ff && !rsp_stall) |=>
      (res_valid_ff && rsp_last && rsp_char_valid && rsp_character == SPACE_CHAR))
      else $error("word end beat is not a space");

   a_two_beats_carry_char: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_two_ff) |-> res_char_valid_ff)
      else $error("word end without a letter");

   a_hold_input_on_pair: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_two_ff) |-> req_stall)
      else $error("input accepted while a beat pair is pending");

   a_idle_gap_clear: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (gap_ff == '0))
      else $error("gap counter runs while idle");

   a_led_needs_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_led_on) |-> was_down_ff)
      else $error("lamp lit with key released");
`endif

endmodule
